FILE: rtl/core/slmw_pkg.sv
`default_nettype none
package slmw_pkg;

   // matrix geometry
   localparam int ROWS       = 18;
   localparam int COLS       = 11;
   localparam int MAX_SKIPS  = 4;
   localparam int SKIP_SLOTS = 4;

   // field widths
   localparam int COL_W      = 5;
   localparam int ROW_W      = 5;
   localparam int IDX_W      = 10;
   localparam int CHAIN_W    = 11;
   localparam int CHUNK_W    = 7;
   localparam int SKIP_W     = 3;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_RIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BOTTOM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_POS_A   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_POS_B   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_POS_C   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_POS_D   = 3'd6;

   typedef struct packed {
      logic load;   // accept beat: emit entry, move walk
      logic step;   // one chain advance iteration
   } slmw_cmd_type;

   typedef struct packed {
      logic last;      // entry being loaded is the final one
      logic adv_done;  // this iteration ends the chain advance
   } slmw_sts_type;

   typedef struct packed {
      logic [IDX_W-1:0]   map_index;
      logic [CHAIN_W-1:0] led_number;
      logic               last_entry;
   } slmw_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/slmw_ctrl.sv
`default_nettype none
module slmw_ctrl
   import slmw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         buf_space,
   input  wire slmw_sts_type sts,
   output logic              req_ready,
   output slmw_cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_ADV
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == ST_IDLE) && buf_space;

   always_comb begin
      cmd.load = req_valid && req_ready;
      cmd.step = (state_ff == ST_ADV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load && !sts.last) state_ff <= ST_ADV;
            end
            ST_ADV: begin
               if (sts.adv_done) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV) |-> !req_ready)
      else $error("request accepted during chain advance");

endmodule
`default_nettype wire

FILE: rtl/core/slmw_dpath.sv
`default_nettype none
module slmw_dpath
   import slmw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_restart,
   input  wire slmw_cmd_type          cmd,
   output slmw_sts_type               sts,
   output slmw_rsp_type               rsp
);

   // config
   logic                first_right_ff;
   logic                first_bottom_ff;
   logic [SKIP_W-1:0]   skip_count_ff;
   logic [POS_W-1:0]    skip_pos_ff [SKIP_SLOTS];

   // walk state
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                down_ff;
   logic [CHAIN_W-1:0]  chain_ff;
   logic [CHUNK_W-1:0]  chunk_ff;
   logic [CHUNK_W-1:0]  guard_ff;

   logic [SKIP_W-1:0]   skips;
   logic [CHUNK_W-1:0]  len;
   logic [CHUNK_W-1:0]  period;
   logic [COL_W-1:0]    start_col;
   logic [ROW_W-1:0]    start_row;
   logic                start_down;
   logic [COL_W-1:0]    eff_col;
   logic [ROW_W-1:0]    eff_row;
   logic                eff_down;
   logic [CHAIN_W-1:0]  eff_chain;
   logic [CHUNK_W-1:0]  eff_chunk;
   logic                col_end;
   logic [COL_W-1:0]    last_col;
   logic                last;

   logic [COL_W-1:0]    col_in;
   logic [ROW_W-1:0]    row_in;
   logic                down_in;
   logic [CHUNK_W:0]    chunk_inc;
   logic [CHUNK_W-1:0]  chunk_nx;
   logic [CHUNK_W-1:0]  mirrored;
   logic [CHUNK_W-1:0]  guard_nx;
   logic                hit;

   assign skips  = (skip_count_ff > SKIP_W'(MAX_SKIPS)) ? SKIP_W'(MAX_SKIPS) : skip_count_ff;
   assign len    = CHUNK_W'(ROWS) + CHUNK_W'(skips);
   assign period = {len[CHUNK_W-2:0], 1'b0};

   assign start_col  = first_right_ff ? COL_W'(COLS - 1) : '0;
   assign start_down = !first_bottom_ff;
   assign start_row  = start_down ? ROW_W'(ROWS - 1) : '0;

   assign eff_col   = req_restart ? start_col  : col_ff;
   assign eff_row   = req_restart ? start_row  : row_ff;
   assign eff_down  = req_restart ? start_down : down_ff;
   assign eff_chain = req_restart ? '0 : chain_ff;
   assign eff_chunk = req_restart ? '0 : chunk_ff;

   assign col_end  = eff_down ? (eff_row == '0) : (eff_row >= ROW_W'(ROWS - 1));
   assign last_col = first_right_ff ? '0 : COL_W'(COLS - 1);
   assign last     = col_end && (eff_col == last_col);

   always_comb begin
      rsp.map_index  = IDX_W'({{(IDX_W-COL_W){1'b0}}, eff_col} * IDX_W'(ROWS))
                       + IDX_W'(eff_row);
      rsp.led_number = eff_chain;
      rsp.last_entry = last;
   end

   // serpentine step of row and column
   always_comb begin
      col_in  = eff_col;
      row_in  = eff_row;
      down_in = eff_down;
      if (col_end) begin
         if (first_right_ff) begin
            if (eff_col > '0) col_in = eff_col - COL_W'(1);
         end else begin
            if (eff_col < COL_W'(COLS - 1)) col_in = eff_col + COL_W'(1);
         end
         down_in = !eff_down;
      end else if (eff_down) begin
         row_in = eff_row - ROW_W'(1);
      end else begin
         row_in = eff_row + ROW_W'(1);
      end
   end

   // one chain advance iteration; upper half of chunk is mirrored
   always_comb begin
      hit = 1'b0;
      chunk_inc = {1'b0, chunk_ff} + (CHUNK_W+1)'(1);
      chunk_nx  = (chunk_inc >= {1'b0, period}) ? '0 : chunk_inc[CHUNK_W-1:0];
      mirrored  = (chunk_nx < len) ? chunk_nx : (period - CHUNK_W'(1) - chunk_nx);
      for (int i = 0; i < SKIP_SLOTS; i++) begin
         if ((SKIP_W'(i) < skips) && ({1'b0, skip_pos_ff[i]} == mirrored)) hit = 1'b1;
      end
      guard_nx = guard_ff + CHUNK_W'(1);
   end

   always_comb begin
      sts.last     = last;
      sts.adv_done = !hit || (guard_nx >= period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_right_ff  <= 1'b0;
         first_bottom_ff <= 1'b0;
         skip_count_ff   <= '0;
         for (int i = 0; i < SKIP_SLOTS; i++) skip_pos_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_RIGHT:  first_right_ff  <= csr_data[0];
            CSR_FIRST_BOTTOM: first_bottom_ff <= csr_data[0];
            CSR_SKIP_COUNT:   skip_count_ff   <= csr_data[SKIP_W-1:0];
            CSR_SKIP_POS_A:   skip_pos_ff[0]  <= csr_data;
            CSR_SKIP_POS_B:   skip_pos_ff[1]  <= csr_data;
            CSR_SKIP_POS_C:   skip_pos_ff[2]  <= csr_data;
            CSR_SKIP_POS_D:   skip_pos_ff[3]  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= ROW_W'(ROWS - 1);
         down_ff  <= 1'b1;
         chain_ff <= '0;
         chunk_ff <= '0;
         guard_ff <= '0;
      end else if (cmd.load) begin
         guard_ff <= '0;
         if (last) begin
            col_ff   <= start_col;
            row_ff   <= start_row;
            down_ff  <= start_down;
            chain_ff <= '0;
            chunk_ff <= '0;
         end else begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            down_ff  <= down_in;
            chain_ff <= eff_chain;
            chunk_ff <= eff_chunk;
         end
      end else if (cmd.step) begin
         chain_ff <= chain_ff + CHAIN_W'(1);
         chunk_ff <= chunk_nx;
         guard_ff <= guard_nx;
      end
   end

   a_guard_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (guard_ff < period))
      else $error("chain advance ran past one chunk");

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && last) |=> (chain_ff == '0) && (chunk_ff == '0))
      else $error("walk did not wrap to chain start");

endmodule
`default_nettype wire

FILE: rtl/core/slmw_obuf.sv
`default_nettype none
module slmw_obuf
   import slmw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire slmw_rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output slmw_rsp_type      rsp_data
);

   logic         out_valid_ff;
   logic         hold_valid_ff;
   slmw_rsp_type out_ff;
   slmw_rsp_type hold_ff;
   logic         out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign space     = !hold_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (hold_valid_ff) begin
            out_ff        <= hold_ff;
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
            if (push) out_ff <= push_data;
         end
      end else if (push) begin
         hold_ff       <= push_data;
         hold_valid_ff <= 1'b1;
      end
   end

   a_hold_behind_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> out_valid_ff)
      else $error("skid slot full with output register empty");

endmodule
`default_nettype wire

FILE: rtl/core/serpentine_led_map_walker.sv
`default_nettype none
// A taken request beat is registered into the output register, or into the
// skid slot while the output is stalled. After each entry but the final one
//   of the map, the chain advance loop runs, one position per cycle, passing
//   skipped chain positions; no request beat is taken until it ends.
// Reset: synchronous, active high; config registers clear to zero and the walk
//   sits at its first entry (column 0, top row, heading down). No clearing pass.
module serpentine_led_map_walker
   import slmw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_restart,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [IDX_W-1:0]           rsp_map_index,
   output logic [CHAIN_W-1:0]         rsp_led_number,
   output logic                       rsp_last_entry,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   slmw_cmd_type cmd;
   slmw_sts_type sts;
   slmw_rsp_type entry;
   slmw_rsp_type rsp_data;
   logic         buf_space;

   // registers always take a write beat
   assign csr_ready = 1'b1;

   // controller: idle / chain-advance sequencing, request handshake
   slmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .buf_space (buf_space),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // datapath: config, walk position, chain counter, skip match
   slmw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_restart (req_restart),
      .cmd         (cmd),
      .sts         (sts),
      .rsp         (entry)
   );

   // output register plus skid slot, so a request beat can be taken while
   // a result beat still waits
   slmw_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.load),
      .push_data (entry),
      .space     (buf_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_map_index  = rsp_data.map_index;
   assign rsp_led_number = rsp_data.led_number;
   assign rsp_last_entry = rsp_data.last_entry;

endmodule
`default_nettype wire
